// ----- sv/sdfc_pkg.sv -----
// Shared types and constants for the status datagram frame checker.
package sdfc_pkg;

	localparam int unsigned PhaseW = 4;
	localparam int unsigned CountW = 16;
	localparam int unsigned ErrW   = 3;

	localparam logic [PhaseW-1:0] PH_IDLE  = 4'd0;
	localparam logic [PhaseW-1:0] PH_PRE   = 4'd1;
	localparam logic [PhaseW-1:0] PH_SYNC  = 4'd2;
	localparam logic [PhaseW-1:0] PH_LENLO = 4'd3;
	localparam logic [PhaseW-1:0] PH_LENHI = 4'd4;
	localparam logic [PhaseW-1:0] PH_TYPE  = 4'd5;
	localparam logic [PhaseW-1:0] PH_PAY   = 4'd6;
	localparam logic [PhaseW-1:0] PH_SUM   = 4'd7;
	localparam logic [PhaseW-1:0] PH_T55   = 4'd8;
	localparam logic [PhaseW-1:0] PH_TED   = 4'd9;

	localparam logic [ErrW-1:0] ERR_NONE  = 3'd0;
	localparam logic [ErrW-1:0] ERR_PRE   = 3'd1;
	localparam logic [ErrW-1:0] ERR_SYNC  = 3'd2;
	localparam logic [ErrW-1:0] ERR_SUM   = 3'd3;
	localparam logic [ErrW-1:0] ERR_T55   = 3'd4;
	localparam logic [ErrW-1:0] ERR_TED   = 3'd5;
	localparam logic [ErrW-1:0] ERR_TRUNC = 3'd6;

	localparam logic [7:0] PREAMBLE_BYTE = 8'hBE;
	localparam logic [7:0] SYNC_BYTE     = 8'hAA;
	localparam logic [7:0] TRAIL55_BYTE  = 8'h55;
	localparam logic [7:0] TRAILED_BYTE  = 8'hED;
	localparam logic [7:0] INFO_TYPE_RST = 8'h01;

	localparam logic [CountW-1:0] RUN_LAST = 16'd7;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       first_byte;
		logic       last_byte;
	} beat_in_t;

	typedef struct packed {
		logic [7:0]      payload_byte;
		logic            payload_valid;
		logic            frame_done;
		logic            frame_good;
		logic [ErrW-1:0] error_code;
		logic [7:0]      frame_type;
		logic            is_info_frame;
	} beat_out_t;

endpackage

// ----- sv/sdfc_if.sv -----
// Valid/ready stream interfaces for input bytes and check results.
interface sdfc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       first_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output first_byte, output last_byte,
		input ready);
	modport sink (input valid, input data_byte, input first_byte, input last_byte,
		output ready);
endinterface

interface sdfc_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] payload_byte;
	logic       payload_valid;
	logic       frame_done;
	logic       frame_good;
	logic [2:0] error_code;
	logic [7:0] frame_type;
	logic       is_info_frame;

	modport source (output valid, output payload_byte, output payload_valid,
		output frame_done, output frame_good, output error_code, output frame_type,
		output is_info_frame, input ready);
	modport sink (input valid, input payload_byte, input payload_valid,
		input frame_done, input frame_good, input error_code, input frame_type,
		input is_info_frame, output ready);
endinterface

// ----- sv/sdfc_core.sv -----
// Frame state and per-byte check logic.
module sdfc_core import sdfc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  beat_in_t   beat,
	input  logic [7:0] info_type,
	output beat_out_t  res
);

	logic [PhaseW-1:0] phase_q, phase_c, phase_d;
	logic [CountW-1:0] count_q, count_c, count_d, count_inc;
	logic [CountW-1:0] len_q, len_c, len_d;
	logic [7:0]        sum_q, sum_c, sum_d;
	logic [7:0]        type_q, type_c, type_d;
	logic [7:0]        b;
	logic [7:0]        run_want;
	logic [PhaseW-1:0] run_next;
	logic [ErrW-1:0]   run_err;
	logic [ErrW-1:0]   err;
	logic              pvalid, done, good, is_run;

	assign b = beat.data_byte;

	always_comb begin
		phase_c = beat.first_byte ? PH_PRE : phase_q;
		count_c = beat.first_byte ? '0 : count_q;
		len_c   = beat.first_byte ? '0 : len_q;
		sum_c   = beat.first_byte ? '0 : sum_q;
		type_c  = beat.first_byte ? '0 : type_q;
	end

	assign count_inc = count_c + 16'd1;

	// marker runs of eight bytes
	always_comb begin
		is_run   = 1'b1;
		run_want = PREAMBLE_BYTE;
		run_next = PH_SYNC;
		run_err  = ERR_PRE;
		case (phase_c)
			PH_PRE: begin
				run_want = PREAMBLE_BYTE; run_next = PH_SYNC; run_err = ERR_PRE;
			end
			PH_SYNC: begin
				run_want = SYNC_BYTE; run_next = PH_LENLO; run_err = ERR_SYNC;
			end
			PH_T55: begin
				run_want = TRAIL55_BYTE; run_next = PH_TED; run_err = ERR_T55;
			end
			PH_TED: begin
				run_want = TRAILED_BYTE; run_next = PH_IDLE; run_err = ERR_TED;
			end
			default: is_run = 1'b0;
		endcase
	end

	always_comb begin
		phase_d = phase_c;
		count_d = count_c;
		len_d   = len_c;
		sum_d   = sum_c;
		type_d  = type_c;
		pvalid  = 1'b0;
		done    = 1'b0;
		good    = 1'b0;
		err     = ERR_NONE;
		if (phase_c != PH_IDLE) begin
			if (is_run) begin
				if (b != run_want) begin
					err = run_err;
				end else if (count_c >= RUN_LAST) begin
					count_d = '0;
					phase_d = run_next;
					if (phase_c == PH_TED) begin
						done = 1'b1;
						good = 1'b1;
					end
				end else begin
					count_d = count_inc;
				end
			end else begin
				case (phase_c)
					PH_LENLO: begin
						len_d   = {8'd0, b};
						phase_d = PH_LENHI;
					end
					PH_LENHI: begin
						len_d   = {b, len_c[7:0]};
						phase_d = PH_TYPE;
					end
					PH_TYPE: begin
						type_d  = b;
						count_d = '0;
						phase_d = (len_c == '0) ? PH_SUM : PH_PAY;
					end
					PH_PAY: begin
						pvalid = 1'b1;
						sum_d  = sum_c + b;
						if (count_inc >= len_c) begin
							count_d = '0;
							phase_d = PH_SUM;
						end else begin
							count_d = count_inc;
						end
					end
					PH_SUM: begin
						if (b != sum_c) begin
							err = ERR_SUM;
						end else begin
							count_d = '0;
							phase_d = PH_T55;
						end
					end
					default: phase_d = PH_IDLE;
				endcase
			end
			if (err != ERR_NONE) begin
				done    = 1'b1;
				phase_d = PH_IDLE;
			end else if (!done && beat.last_byte && phase_d != PH_IDLE) begin
				done    = 1'b1;
				err     = ERR_TRUNC;
				phase_d = PH_IDLE;
			end
		end
	end

	always_comb begin
		res.payload_byte  = pvalid ? b : 8'd0;
		res.payload_valid = pvalid;
		res.frame_done    = done;
		res.frame_good    = good;
		res.error_code    = err;
		res.frame_type    = type_d;
		res.is_info_frame = good && (type_d == info_type);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			count_q <= '0;
			len_q   <= '0;
			sum_q   <= '0;
			type_q  <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			count_q <= count_d;
			len_q   <= len_d;
			sum_q   <= sum_d;
			type_q  <= type_d;
		end
	end

endmodule

// ----- sv/status_datagram_frame_checker.sv -----
// Status datagram frame checker: one datagram byte in, one check result out per beat,
// sustaining one beat per clock unless tx.ready stalls the output; each beat passes the
// input register, then the frame state update into the result register. Every input beat
// yields exactly one result beat, in order, including bytes that fall outside a frame.
module status_datagram_frame_checker import sdfc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	sdfc_in_if.sink    rx,
	sdfc_out_if.source tx,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata
);

	logic       valid_s1;
	beat_in_t   beat_s1;
	logic       valid_s2;
	beat_out_t  res_s2;
	beat_out_t  res;
	logic [7:0] info_type_q;
	logic       adv, step;

	assign adv      = !valid_s2 || tx.ready;
	assign step     = valid_s1 && adv;
	assign rx.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			info_type_q <= INFO_TYPE_RST;
		end else if (cfg_we) begin
			info_type_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (rx.ready) begin
				valid_s1 <= rx.valid;
			end
			if (adv) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			beat_s1 <= '{data_byte: rx.data_byte, first_byte: rx.first_byte,
				last_byte: rx.last_byte};
		end
		if (step) begin
			res_s2 <= res;
		end
	end

	sdfc_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.beat      (beat_s1),
		.info_type (info_type_q),
		.res       (res)
	);

	assign tx.valid         = valid_s2;
	assign tx.payload_byte  = res_s2.payload_byte;
	assign tx.payload_valid = res_s2.payload_valid;
	assign tx.frame_done    = res_s2.frame_done;
	assign tx.frame_good    = res_s2.frame_good;
	assign tx.error_code    = res_s2.error_code;
	assign tx.frame_type    = res_s2.frame_type;
	assign tx.is_info_frame = res_s2.is_info_frame;

endmodule
